// ----- hdl/sedh_pkg.sv -----
// Shared constants, types and fixed-point helpers for the serpentine
// error-diffusion halftoner. No dependencies.
`timescale 1ns / 1ps

package sedh_pkg;

	// default column capacity of the line store
	localparam int MAX_WIDTH_DEF = 1024;

	// configuration port
	localparam int CFG_AW = 1;
	localparam int CFG_DW = 11;
	localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_AW-1:0] REG_THRESHOLD   = 1'd1;
	localparam logic [CFG_DW-1:0] IMAGE_WIDTH_RST = 11'd500;
	localparam logic [7:0]        THRESHOLD_RST   = 8'd128;

	// channels, Q10.4 error width, arithmetic width
	localparam int NCH    = 3;
	localparam int QW     = 14;
	localparam int CALC_W = 18;

	// frame epoch tag kept with each line-store entry
	localparam int EPOCH_W = 4;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

	typedef logic signed [QW-1:0]     q_t;
	typedef logic signed [CALC_W-1:0] calc_t;
	typedef logic [NCH-1:0][QW-1:0]   err_vec_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		err_vec_t           err;
	} line_ent_t;

	localparam calc_t Q_MAX      = 18'sd8191;
	localparam calc_t Q_MIN      = -18'sd8192;
	localparam calc_t FULL_SCALE = 18'sd4080;

	// clamp to the Q10.4 range
	function automatic q_t sat_q(input calc_t x);
		q_t r;
		if (x > Q_MAX) begin
			r = Q_MAX[QW-1:0];
		end else if (x < Q_MIN) begin
			r = Q_MIN[QW-1:0];
		end else begin
			r = x[QW-1:0];
		end
		return r;
	endfunction

	// floor(x / 16); callers keep the result inside the Q10.4 range
	function automatic q_t share_q(input calc_t x);
		calc_t s;
		s = x >>> 4;
		return s[QW-1:0];
	endfunction

endpackage

// ----- hdl/serpentine_error_diffusion_halftone_top.sv -----
// Serpentine Floyd-Steinberg halftoner for RGB pixel streams.
// Depends on sedh_pkg (constants, line-store entry type, saturate/share helpers).
`timescale 1ns / 1ps

// One item in, one item out: each accepted RGB pixel yields three halftone
// bits and a row-end flag through the stage-1 and output registers, and a new
// pixel can be taken every clock while the output is not stalled and no
// sweep runs. Pixels come in scan order (even rows left to right, odd rows
// right to left); s_axis_tuser marks the first pixel of a frame. The
// sustained rate is set by the per-channel error carry (sample + ahead
// error + stored error, threshold, share back into the ahead register),
// which closes combinationally in stage 1. Next-row errors live in two
// column-parity banks of (MAX_WIDTH+1)/2 entries each, so the write to the
// pixel behind and the write to the current column land in different banks;
// a one-entry bypass covers a read that hits the write made in the same
// cycle. Each entry carries a frame epoch tag, so a frame start clears the
// store without a sweep. After reset the banks are swept one entry per cycle
// with s_axis_tready low. At every sixteenth frame start, when the epoch tag
// wraps, the same sweep runs; the frame start is held off from the cycle it
// is presented, the sweep begins once stage 1 is empty, and tready stays low
// until the sweep ends. Configuration writes are taken at any time. Width is
// clamped to 2..MAX_WIDTH; write configuration only when idle.
module serpentine_error_diffusion_halftone_top
	import sedh_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data,
	// pixel input
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [23:0]       s_axis_tdata,  // red_in[7:0], green_in[15:8], blue_in[23:16]
	input  logic              s_axis_tuser,  // start_of_frame
	// halftone output
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // red_bit[0], green_bit[1], blue_bit[2], zeros
	output logic              m_axis_tlast   // row_end
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WB  = CW + 1;
	localparam int EW  = (WB > CFG_DW) ? WB : CFG_DW;
	localparam int BD  = (MAX_WIDTH + 1) / 2;
	localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
	localparam logic [BAW-1:0] BANK_LAST = BAW'(BD - 1);

	// configuration
	logic [CFG_DW-1:0]  image_width_q;
	logic [7:0]         threshold_q;

	// scan position and store housekeeping
	logic [CW-1:0]      rp_q;
	logic               odd_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               clear_busy_q;
	logic [BAW-1:0]     clr_idx_q;
	logic               wrap_clean_q;

	// stage 1
	logic               s1_valid_q;
	logic [7:0]         pix_s1 [NCH];
	logic               sof_s1;
	logic               first_s1;
	logic               last_s1;
	logic [CW-1:0]      col_s1;
	logic [CW-1:0]      behind_s1;
	logic [EPOCH_W-1:0] ep_s1;
	logic               fwd_valid_s1;
	err_vec_t           fwd_s1;
	line_ent_t          bank0_rd_s1;
	line_ent_t          bank1_rd_s1;

	// row carries
	q_t                 ahead_q     [NCH];
	q_t                 pend_here_q [NCH];
	q_t                 pend_next_q [NCH];

	// output register
	logic               out_valid_q;
	logic [NCH-1:0]     out_bits_q;
	logic               out_last_q;

	// line store banks: even columns in bank 0, odd in bank 1
	line_ent_t          bank0_mem [BD];
	line_ent_t          bank1_mem [BD];

	// ---------------- input side ----------------
	logic               in_sof;
	logic               wrap_req;
	logic               proc;
	logic               accept;
	logic [EW-1:0]      iw_x;
	logic [WB-1:0]      w_eff;
	logic [CW-1:0]      wm1;
	logic [CW-1:0]      rp0;
	logic [CW-1:0]      rp_c;
	logic               odd0;
	logic [CW-1:0]      col_in;
	logic [CW-1:0]      behind_in;
	logic               last_in;
	logic               first_in;
	logic [EPOCH_W-1:0] ep_in;
	logic [BAW-1:0]     rd_idx;

	assign in_sof   = s_axis_tuser;
	// a frame start that would reuse a stale epoch waits for a sweep
	assign wrap_req = s_axis_tvalid && in_sof && (epoch_q == EPOCH_LAST) && !wrap_clean_q;
	assign proc     = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (!s1_valid_q || proc) && !clear_busy_q && !wrap_req;
	assign accept   = s_axis_tvalid && s_axis_tready;

	always_comb begin
		iw_x = EW'(image_width_q);
		if (iw_x < EW'(2)) begin
			w_eff = WB'(2);
		end else if (iw_x > EW'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(iw_x);
		end
		wm1       = CW'(w_eff - WB'(1));
		rp0       = in_sof ? '0 : rp_q;
		odd0      = in_sof ? 1'b0 : odd_q;
		// width shrunk under us: this pixel closes the row
		rp_c      = (rp0 > wm1) ? wm1 : rp0;
		col_in    = odd0 ? (wm1 - rp_c) : rp_c;
		behind_in = odd0 ? (col_in + CW'(1)) : (col_in - CW'(1));
		last_in   = (rp_c == wm1);
		first_in  = (rp_c == '0);
		ep_in     = in_sof ? (epoch_q + EPOCH_W'(1)) : epoch_q;
		rd_idx    = BAW'(col_in >> 1);
	end

	// ---------------- stage 1 datapath ----------------
	line_ent_t          ent_s1;
	logic               mem_ok;
	err_vec_t           mem_err;
	calc_t              thr16;
	q_t                 a_c      [NCH];
	q_t                 ph_c     [NCH];
	q_t                 pn_c     [NCH];
	calc_t              sum_c    [NCH];
	q_t                 s_c      [NCH];
	logic [NCH-1:0]     bit_c;
	calc_t              e_c      [NCH];
	q_t                 ahead_nx [NCH];
	q_t                 here_c   [NCH];
	q_t                 pnext_nx [NCH];
	err_vec_t           here_vec;
	err_vec_t           behind_vec;
	err_vec_t           col_val;

	always_comb begin
		ent_s1  = col_s1[0] ? bank1_rd_s1 : bank0_rd_s1;
		mem_ok  = !sof_s1 && (ent_s1.tag == ep_s1);
		if (fwd_valid_s1) begin
			mem_err = fwd_s1;
		end else if (mem_ok) begin
			mem_err = ent_s1.err;
		end else begin
			mem_err = '0;
		end
		thr16 = calc_t'({threshold_q, 4'b0000});
		for (int ch = 0; ch < NCH; ch++) begin
			// carries do not cross a row edge
			a_c[ch]   = first_s1 ? '0 : ahead_q[ch];
			ph_c[ch]  = first_s1 ? '0 : pend_here_q[ch];
			pn_c[ch]  = first_s1 ? '0 : pend_next_q[ch];
			sum_c[ch] = calc_t'({pix_s1[ch], 4'b0000}) + calc_t'(a_c[ch])
				+ calc_t'(q_t'(mem_err[ch]));
			s_c[ch]   = sat_q(sum_c[ch]);
			bit_c[ch] = (calc_t'(s_c[ch]) >= thr16);
			e_c[ch]   = calc_t'(s_c[ch]) - (bit_c[ch] ? FULL_SCALE : calc_t'(0));
			ahead_nx[ch]   = share_q(e_c[ch] * 18'sd7);
			behind_vec[ch] = sat_q(calc_t'(ph_c[ch]) + calc_t'(share_q(e_c[ch] * 18'sd3)));
			here_c[ch]     = sat_q(calc_t'(pn_c[ch]) + calc_t'(share_q(e_c[ch] * 18'sd5)));
			here_vec[ch]   = here_c[ch];
			pnext_nx[ch]   = share_q(e_c[ch]);
		end
		// current column is consumed; the row's last pixel parks its below share there
		col_val = last_s1 ? here_vec : '0;
	end

	// ---------------- bank write ports ----------------
	logic               we0;
	logic               we1;
	logic [BAW-1:0]     wa0;
	logic [BAW-1:0]     wa1;
	line_ent_t          wd0;
	line_ent_t          wd1;
	logic [BAW-1:0]     col_idx_s1;
	logic [BAW-1:0]     behind_idx_s1;

	assign col_idx_s1    = BAW'(col_s1 >> 1);
	assign behind_idx_s1 = BAW'(behind_s1 >> 1);

	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wa0 = clr_idx_q;
		wa1 = clr_idx_q;
		wd0 = '{tag: EPOCH_LAST, err: '0};
		wd1 = '{tag: EPOCH_LAST, err: '0};
		if (clear_busy_q) begin
			we0 = 1'b1;
			we1 = 1'b1;
		end else if (proc) begin
			// col and behind are neighbors, so they sit in opposite banks
			if (col_s1[0]) begin
				we1 = 1'b1;
				wa1 = col_idx_s1;
				wd1 = '{tag: ep_s1, err: col_val};
				we0 = !first_s1;
				wa0 = behind_idx_s1;
				wd0 = '{tag: ep_s1, err: behind_vec};
			end else begin
				we0 = 1'b1;
				wa0 = col_idx_s1;
				wd0 = '{tag: ep_s1, err: col_val};
				we1 = !first_s1;
				wa1 = behind_idx_s1;
				wd1 = '{tag: ep_s1, err: behind_vec};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			bank0_mem[wa0] <= wd0;
		end
		if (accept) begin
			bank0_rd_s1 <= bank0_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			bank1_mem[wa1] <= wd1;
		end
		if (accept) begin
			bank1_rd_s1 <= bank1_mem[rd_idx];
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			threshold_q   <= THRESHOLD_RST;
			rp_q          <= '0;
			odd_q         <= 1'b0;
			epoch_q       <= '0;
			clear_busy_q  <= 1'b1;
			clr_idx_q     <= '0;
			wrap_clean_q  <= 1'b0;
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_IMAGE_WIDTH: image_width_q <= cfg_data;
					REG_THRESHOLD:   threshold_q   <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (accept) begin
				if (last_in) begin
					rp_q  <= '0;
					odd_q <= !odd0;
				end else begin
					rp_q  <= rp_c + CW'(1);
					odd_q <= odd0;
				end
				if (in_sof) begin
					epoch_q      <= epoch_q + EPOCH_W'(1);
					wrap_clean_q <= 1'b0;
				end
			end

			// sweep: tags go to the last epoch, stale for the epochs that follow
			if (clear_busy_q) begin
				if (clr_idx_q == BANK_LAST) begin
					clear_busy_q <= 1'b0;
					clr_idx_q    <= '0;
					wrap_clean_q <= 1'b1;
				end else begin
					clr_idx_q <= clr_idx_q + BAW'(1);
				end
			end else if (wrap_req && !s1_valid_q) begin
				clear_busy_q <= 1'b1;
				clr_idx_q    <= '0;
			end

			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (proc) begin
				s1_valid_q <= 1'b0;
			end

			if (proc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int ch = 0; ch < NCH; ch++) begin
				pix_s1[ch] <= s_axis_tdata[ch*8 +: 8];
			end
			sof_s1    <= in_sof;
			first_s1  <= first_in;
			last_s1   <= last_in;
			col_s1    <= col_in;
			behind_s1 <= behind_in;
			ep_s1     <= ep_in;
			// bypass the entry that the item in stage 1 writes this same cycle
			fwd_valid_s1 <= proc && !in_sof
				&& ((col_in == col_s1) || (!first_s1 && (col_in == behind_s1)));
			fwd_s1 <= (col_in == col_s1) ? col_val : behind_vec;
		end
		if (proc) begin
			for (int ch = 0; ch < NCH; ch++) begin
				ahead_q[ch]     <= ahead_nx[ch];
				pend_here_q[ch] <= here_c[ch];
				pend_next_q[ch] <= pnext_nx[ch];
			end
			out_bits_q <= bit_c;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8 - NCH){1'b0}}, out_bits_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- verif/halftone_checker.sv -----
// Checker for the serpentine error-diffusion halftoner: watches the pixel,
// halftone and register channels, predicts each result and compares it.
// Depends on sedh_pkg (Q10.4 type, register indexes, reset values).
`timescale 1ns / 1ps

module halftone_checker
	import sedh_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [23:0]       s_axis_tdata,  // red_in[7:0], green_in[15:8], blue_in[23:16]
	input  logic              s_axis_tuser,  // start_of_frame
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [7:0]        m_axis_tdata,  // red_bit[0], green_bit[1], blue_bit[2], zeros
	input  logic              m_axis_tlast,  // row_end
	output int                mismatch_count,
	output int                pending_count
);

	typedef struct {
		logic red;
		logic green;
		logic blue;
		logic row_end;
	} halftone_t;

	localparam int FULL_Q   = 4080;
	localparam int Q_TOP    = 8191;
	localparam int Q_BOTTOM = -8192;
	localparam int PRINT_CAP = 20;

	// predictor state
	q_t                line_err [MAX_WIDTH][NCH];
	q_t                ahead_err [NCH];
	q_t                pend_here [NCH];
	q_t                pend_next [NCH];
	logic [CFG_DW-1:0] width_reg;
	logic [7:0]        thresh_reg;
	int                row_pos;
	bit                odd_row;

	halftone_t expected_bits[$];

	function automatic q_t clamp_q(input int x);
		int r;
		r = x;
		if (r > Q_TOP) r = Q_TOP;
		if (r < Q_BOTTOM) r = Q_BOTTOM;
		return q_t'(r);
	endfunction

	// arithmetic shift on a signed int floors
	function automatic int floor16(input int x);
		return x >>> 4;
	endfunction

	task automatic clear_state();
		int c;
		foreach (line_err[i, k]) line_err[i][k] = '0;
		for (c = 0; c < NCH; c++) begin
			ahead_err[c] = '0;
			pend_here[c] = '0;
			pend_next[c] = '0;
		end
		row_pos = 0;
		odd_row = 1'b0;
	endtask

	task automatic halftone_pixel(input logic sof, input logic [23:0] rgb,
			output halftone_t res);
		int w, col, behind, v, s, e, here, thr16, ch;
		bit last;
		logic [NCH-1:0] bits;
		if (sof) begin
			foreach (line_err[i, k]) line_err[i][k] = '0;
			row_pos = 0;
			odd_row = 1'b0;
		end
		w = width_reg;
		if (w < 2) w = 2;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		// width shrunk below the current position: this pixel closes the row
		if (row_pos >= w) row_pos = w - 1;
		// no error crosses a row edge
		if (row_pos == 0) begin
			for (ch = 0; ch < NCH; ch++) begin
				ahead_err[ch] = '0;
				pend_here[ch] = '0;
				pend_next[ch] = '0;
			end
		end
		col = odd_row ? (w - 1 - row_pos) : row_pos;
		last = (row_pos == w - 1);
		behind = 0;
		if (row_pos > 0) behind = odd_row ? col + 1 : col - 1;
		thr16 = thresh_reg;
		thr16 = thr16 * 16;
		for (ch = 0; ch < NCH; ch++) begin
			v = rgb[8*ch +: 8];
			v = v * 16;
			s = clamp_q(v + ahead_err[ch] + line_err[col][ch]);
			bits[ch] = (s >= thr16);
			e = s - (bits[ch] ? FULL_Q : 0);
			line_err[col][ch] = '0;
			ahead_err[ch] = q_t'(floor16(7 * e));
			if (row_pos > 0) line_err[behind][ch] = clamp_q(pend_here[ch] + floor16(3 * e));
			here = clamp_q(pend_next[ch] + floor16(5 * e));
			pend_next[ch] = q_t'(floor16(e));
			pend_here[ch] = q_t'(here);
			if (last) line_err[col][ch] = q_t'(here);
		end
		res.red = bits[0];
		res.green = bits[1];
		res.blue = bits[2];
		res.row_end = last;
		if (last) begin
			row_pos = 0;
			odd_row = !odd_row;
		end else begin
			row_pos++;
		end
	endtask

	always @(posedge clk) begin : monitor
		halftone_t got, want;
		if (!arst_n) begin
			clear_state();
			width_reg = IMAGE_WIDTH_RST;
			thresh_reg = THRESHOLD_RST;
			expected_bits.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_IMAGE_WIDTH) width_reg = cfg_data;
				else if (cfg_addr == REG_THRESHOLD) thresh_reg = cfg_data[7:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.red = m_axis_tdata[0];
				got.green = m_axis_tdata[1];
				got.blue = m_axis_tdata[2];
				got.row_end = m_axis_tlast;
				if (expected_bits.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= PRINT_CAP)
						$display("%0t: unexpected halftone item, expected none, got r%b g%b b%b last%b",
							$time, got.red, got.green, got.blue, got.row_end);
				end else begin
					want = expected_bits.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
							got.blue !== want.blue || got.row_end !== want.row_end ||
							m_axis_tdata[7:3] !== 5'd0) begin
						mismatch_count++;
						if (mismatch_count <= PRINT_CAP)
							$display("%0t: halftone mismatch, expected r%b g%b b%b last%b pad00, got r%b g%b b%b last%b pad%h",
								$time, want.red, want.green, want.blue, want.row_end,
								got.red, got.green, got.blue, got.row_end, m_axis_tdata[7:3]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				halftone_pixel(s_axis_tuser, s_axis_tdata, want);
				expected_bits.push_back(want);
			end
			pending_count = expected_bits.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the halftoner testbench: clock, reset, pixel stimulus, receiver
// stalls, watchdog and verdict. Depends on sedh_pkg, halftone_checker, the DUT.
`timescale 1ns / 1ps

module testbench
	import sedh_pkg::*;
();

	localparam int STALL_LIMIT   = 4096;  // covers the line-store sweep
	localparam int RANDOM_PIXELS = 540;

	typedef enum int {FILL_NOISE, FILL_FLAT, FILL_EXTREME, FILL_RAMP} fill_kind_t;

	typedef struct {
		logic        sof;
		logic [23:0] rgb;  // blue, green, red from the top byte down
	} pixel_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [23:0]       s_axis_tdata = '0;  // red_in[7:0], green_in[15:8], blue_in[23:16]
	logic              s_axis_tuser = 1'b0; // start_of_frame
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;       // red_bit[0], green_bit[1], blue_bit[2], zeros
	logic              m_axis_tlast;       // row_end

	int mismatch_count;
	int pending_count;

	// stimulus bookkeeping
	pixel_t      pixel_q[$];
	pixel_t      next_pixel;
	int          burst_left = 0;
	int          gap_left = 0;
	bit          steady_send = 1'b0;
	logic [15:0] ready_pattern = 16'hFFFF;
	logic [3:0]  rx_phase = '0;
	int          cur_width = 500;
	int          pixels_sent = 0;
	int          frames_sent = 0;
	int          settings_used = 0;
	int          stall_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	serpentine_error_diffusion_halftone_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	halftone_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// Pixel sender: bursts of random length, each preceded by a random gap
	// (none in steady phases). A held item stays put until tready.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = steady_send ? 0 : $urandom_range(0, 8);
			end
			if (gap_left > 0 || pixel_q.size() == 0) begin
				if (gap_left > 0) gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				next_pixel = pixel_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_pixel.rgb;
				s_axis_tuser <= next_pixel.sof;
				burst_left--;
			end
		end
	end

	// Receiver: tready follows a 16-bit pattern picked per phase
	always @(posedge clk) begin
		rx_phase <= rx_phase + 4'd1;
		m_axis_tready <= arst_n ? ready_pattern[rx_phase] : 1'b0;
	end

	// Watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// both registers, plus the width the block will actually use
	task automatic apply_setting(input logic [CFG_DW-1:0] width, input logic [7:0] thr);
		write_reg(REG_IMAGE_WIDTH, width);
		write_reg(REG_THRESHOLD, {3'd0, thr});
		cur_width = width;
		if (cur_width < 2) cur_width = 2;
		if (cur_width > MAX_WIDTH_DEF) cur_width = MAX_WIDTH_DEF;
		settings_used++;
	endtask

	// new receiver pattern and sender mode for the next phase
	task automatic pick_flow();
		ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
		steady_send = ($urandom_range(0, 3) == 0);
	endtask

	task automatic push_pixel(input logic sof, input logic [23:0] rgb);
		pixel_t p;
		p.sof = sof;
		p.rgb = rgb;
		pixel_q.push_back(p);
		pixels_sent++;
		if (sof) frames_sent++;
	endtask

	function automatic logic [7:0] pick_sample(input fill_kind_t fill, input logic [7:0] base,
			input int idx);
		logic [7:0] v;
		case (fill)
			FILL_FLAT: v = base;
			FILL_RAMP: v = base + 8'(idx);
			FILL_EXTREME: begin
				case ($urandom_range(0, 5))
					0: v = 8'd0;
					1: v = 8'd1;
					2: v = 8'd127;
					3: v = 8'd128;
					4: v = 8'd254;
					default: v = 8'd255;
				endcase
			end
			default: v = 8'($urandom);
		endcase
		return v;
	endfunction

	// One frame of whole rows. A broken frame is cut short, lacks its start
	// mark, or carries a stray start mark partway through.
	task automatic push_frame(input int rows, input fill_kind_t fill, input bit broken);
		int count, i, flaw, stray_at;
		logic [23:0] base;
		logic sof;
		count = rows * cur_width;
		flaw = broken ? $urandom_range(0, 2) : -1;
		base = 24'($urandom);
		if (flaw == 0) count = $urandom_range(1, count);
		stray_at = (flaw == 2) ? $urandom_range(1, count) : -1;
		for (i = 0; i < count; i++) begin
			sof = (i == 0 && flaw != 1) || (i == stray_at);
			push_pixel(sof, {pick_sample(fill, base[23:16], i), pick_sample(fill, base[15:8], i),
				pick_sample(fill, base[7:0], i)});
		end
	endtask

	// everything sent and every halftone item back, then a short pause
	task automatic drain_pipeline();
		@(negedge clk);
		while (pixel_q.size() != 0 || s_axis_tvalid || pending_count != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int start_count, i, rows, frames, pick;
		logic [CFG_DW-1:0] width;
		logic [7:0] thr;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Width 0 acts as 2; threshold 0 makes every non-negative sum a one
		apply_setting(11'd0, 8'd0);
		push_pixel(1'b1, 24'h000000);
		push_pixel(1'b0, 24'hFFFFFF);
		push_pixel(1'b0, 24'h80FF00);
		push_pixel(1'b0, 24'h01807F);
		push_pixel(1'b0, 24'hFFFFFF);
		push_pixel(1'b0, 24'h000000);
		drain_pipeline();

		// Width 1 acts as 2; top threshold
		pick_flow();
		apply_setting(11'd1, 8'd255);
		push_pixel(1'b1, 24'h00FEFF);
		push_pixel(1'b0, 24'hFFFFFF);
		push_pixel(1'b0, 24'hFF00FF);
		push_pixel(1'b0, 24'h000000);
		drain_pipeline();

		// Width 3: error from the bottom row must not leak into the next frame
		pick_flow();
		apply_setting(11'd3, 8'd128);
		push_pixel(1'b1, 24'h7F7F7F);
		push_pixel(1'b0, 24'h808080);
		push_pixel(1'b0, 24'hFF0080);
		push_pixel(1'b0, 24'h00FF7F);
		push_pixel(1'b0, 24'h7F80FF);
		push_pixel(1'b0, 24'h404040);
		push_pixel(1'b1, 24'h7F7F7F);
		drain_pipeline();

		// Width shrinks mid-row: position 4 against width 3 ends the row
		apply_setting(11'd6, 8'd100);
		push_pixel(1'b1, 24'h123456);
		push_pixel(1'b0, 24'hC0A080);
		push_pixel(1'b0, 24'h6464FF);
		push_pixel(1'b0, 24'h636363);
		drain_pipeline();
		apply_setting(11'd3, 8'd100);
		push_pixel(1'b0, 24'h646464);
		push_pixel(1'b0, 24'hFF0000);
		push_pixel(1'b0, 24'h00FF00);
		push_pixel(1'b0, 24'h0000FF);
		drain_pipeline();

		// Top columns without a full-width row: a width-2 row turns the scan,
		// then a width code above the limit starts the reversed row at the top
		// column. A shrink closes that row; after another short row a second
		// reversed pass reads back the errors stored up there.
		ready_pattern = 16'hFFFF;
		steady_send = 1'b1;
		apply_setting(11'd2, 8'($urandom));
		push_pixel(1'b1, 24'($urandom));
		push_pixel(1'b0, 24'($urandom));
		drain_pipeline();
		apply_setting(11'd2047, 8'($urandom));
		for (i = 0; i < 12; i++) push_pixel(1'b0, 24'($urandom));
		drain_pipeline();
		pick_flow();
		apply_setting(11'd12, 8'($urandom));
		push_pixel(1'b0, 24'($urandom));
		drain_pipeline();
		apply_setting(11'd2, 8'($urandom));
		push_pixel(1'b0, 24'($urandom));
		push_pixel(1'b0, 24'($urandom));
		drain_pipeline();
		apply_setting(11'd1024, 8'($urandom));
		for (i = 0; i < 12; i++) push_pixel(1'b0, 24'($urandom));
		drain_pipeline();

		// Random phases: mostly small images built from whole rows
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) width = 11'($urandom_range(2, 8));
			else if (pick < 9) width = 11'($urandom_range(9, 33));
			else width = 11'($urandom_range(0, 2));
			pick = $urandom_range(0, 4);
			thr = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
			pick_flow();
			apply_setting(width, thr);
			frames = $urandom_range(1, 4);
			for (i = 0; i < frames; i++) begin
				rows = $urandom_range(1, 5);
				push_frame(rows, fill_kind_t'($urandom_range(0, 3)), $urandom_range(0, 6) == 0);
			end
			// a little loose noise now and then
			if ($urandom_range(0, 4) == 0) begin
				for (i = 0; i < 3; i++) push_pixel(1'($urandom_range(0, 1)), 24'($urandom));
			end
			drain_pipeline();
		end

		repeat (10) @(posedge clk);
		$display("Covered %0d pixels in %0d frames over %0d register settings,",
			pixels_sent, frames_sent, settings_used);
		$display("widths 2 to 1024 with clamping, threshold extremes, mid-row width change.");
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/sedh_pkg.sv
hdl/serpentine_error_diffusion_halftone_top.sv
verif/halftone_checker.sv
verif/testbench.sv
